// File: hw/rtl/upd_pkg.sv
// upd_pkg: shared types and constants for the url percent decoder
// used by the front, queue and back modules and the top level
// no dependencies

package upd_pkg;

   // character codes
   localparam logic [7:0] CH_PLUS    = 8'h2B;
   localparam logic [7:0] CH_PERCENT = 8'h25;
   localparam logic [7:0] CH_SPACE   = 8'h20;

   // queue between front and back, a power of two
   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

   // most bytes one input transaction can produce
   localparam int MAX_BYTES = 3;

   // one classified input transaction: up to three bytes in order, last on the final one
   typedef struct packed {
      logic [MAX_BYTES-1:0][7:0] bytes;
      logic [1:0]                count;
      logic                      last;
   } entry_type;

endpackage

// File: hw/rtl/upd_req_if.sv
// upd_req_if: encoded byte channel into the decoder
// valid/ready handshake with byte and last flag; no dependencies

interface upd_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] in_byte;
   logic       in_last;

   modport source (output valid, output in_byte, output in_last, input ready);
   modport sink   (input valid, input in_byte, input in_last, output ready);
endinterface

// File: hw/rtl/upd_rsp_if.sv
// upd_rsp_if: decoded byte channel out of the decoder
// valid/ready handshake with byte and last flag; no dependencies

interface upd_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] out_byte;
   logic       out_last;

   modport source (output valid, output out_byte, output out_last, input ready);
   modport sink   (input valid, input out_byte, input out_last, output ready);
endinterface

// File: hw/rtl/upd_front.sv
// upd_front: accepts encoded bytes, tracks escape state, builds queue entries
// depends on upd_pkg and upd_req_if

module upd_front (
   input  logic               clock,
   input  logic               reset,
   upd_req_if.sink            req_if,
   input  logic               q_full,
   output logic               push_valid,
   output upd_pkg::entry_type push_entry
);
   import upd_pkg::*;

   typedef enum logic [1:0] {
      HELD_NONE,
      HELD_PERCENT,
      HELD_DIGIT
   } held_type;

   held_type   held_ff, held_in;
   logic [7:0] digit_ff, digit_in;

   logic       accept;
   logic       is_hex;
   logic       plain_emit;
   logic [7:0] plain_byte;
   entry_type  entry;

   // value of one hex digit, letters of either case
   function automatic logic [3:0] hex_nibble(input logic [7:0] c);
      logic [3:0] v;
      v = c[3:0];
      if (c[6]) begin
         v = c[3:0] + 4'd9;
      end
      return v;
   endfunction

   assign accept        = req_if.valid && req_if.ready;
   assign req_if.ready  = !q_full;
   assign push_valid    = accept && (entry.count != 2'd0);
   assign push_entry    = entry;

   // classify the byte and collect what it emits
   always_comb begin
      case (req_if.in_byte) inside
         [8'h30:8'h39], [8'h41:8'h46], [8'h61:8'h66]: is_hex = 1'b1;
         default:                                     is_hex = 1'b0;
      endcase

      plain_emit = !((req_if.in_byte == CH_PERCENT) && !req_if.in_last);
      plain_byte = (req_if.in_byte == CH_PLUS) ? CH_SPACE : req_if.in_byte;

      entry       = '0;
      entry.last  = req_if.in_last;
      held_in     = held_ff;
      digit_in    = digit_ff;

      case (held_ff)
         HELD_PERCENT: begin
            if (is_hex && !req_if.in_last) begin
               held_in  = HELD_DIGIT;
               digit_in = req_if.in_byte;
            end else begin
               entry.bytes[0] = CH_PERCENT;
               entry.bytes[1] = plain_byte;
               entry.count    = plain_emit ? 2'd2 : 2'd1;
               held_in        = plain_emit ? HELD_NONE : HELD_PERCENT;
            end
         end
         HELD_DIGIT: begin
            if (is_hex) begin
               entry.bytes[0] = {hex_nibble(digit_ff), hex_nibble(req_if.in_byte)};
               entry.count    = 2'd1;
               held_in        = HELD_NONE;
            end else begin
               entry.bytes[0] = CH_PERCENT;
               entry.bytes[1] = digit_ff;
               entry.bytes[2] = plain_byte;
               entry.count    = plain_emit ? 2'd3 : 2'd2;
               held_in        = plain_emit ? HELD_NONE : HELD_PERCENT;
            end
         end
         default: begin
            entry.bytes[0] = plain_byte;
            entry.count    = plain_emit ? 2'd1 : 2'd0;
            held_in        = plain_emit ? HELD_NONE : HELD_PERCENT;
         end
      endcase
   end

   // escape state, advanced per accepted transaction
   always_ff @(posedge clock) begin
      if (reset) begin
         held_ff <= HELD_NONE;
      end else if (accept) begin
         held_ff <= held_in;
      end
      if (accept) begin
         digit_ff <= digit_in;
      end
   end

endmodule

// File: hw/rtl/upd_queue.sv
// upd_queue: small fifo of classified entries between front and back
// depends on upd_pkg

module upd_queue (
   input  logic               clock,
   input  logic               reset,
   input  logic               push_valid,
   input  upd_pkg::entry_type push_entry,
   output logic               full,
   input  logic               pop,
   output logic               head_valid,
   output upd_pkg::entry_type head_entry
);
   import upd_pkg::*;

   entry_type           mem_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [QPTR_W:0]     count_ff, count_in;
   logic                do_push, do_pop;

   assign full       = (count_ff == (QPTR_W+1)'(QUEUE_DEPTH));
   assign head_valid = (count_ff != '0);
   assign head_entry = mem_ff[rd_ptr_ff];

   assign do_push = push_valid && !full;
   assign do_pop  = pop && head_valid;

   // pointer and fill count updates
   always_comb begin
      wr_ptr_in = do_push ? wr_ptr_ff + QPTR_W'(1) : wr_ptr_ff;
      rd_ptr_in = do_pop  ? rd_ptr_ff + QPTR_W'(1) : rd_ptr_ff;
      count_in  = count_ff + (QPTR_W+1)'(do_push) - (QPTR_W+1)'(do_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_entry;
      end
   end

endmodule

// File: hw/rtl/upd_back.sv
// upd_back: walks the bytes of the head entry into the output register
// depends on upd_pkg and upd_rsp_if

module upd_back (
   input  logic               clock,
   input  logic               reset,
   input  logic               head_valid,
   input  upd_pkg::entry_type head_entry,
   output logic               pop,
   upd_rsp_if.source          rsp_if
);
   import upd_pkg::*;

   logic [1:0] sel_ff, sel_in;
   logic       out_valid_ff, out_valid_in;
   logic [7:0] out_byte_ff, out_byte_in;
   logic       out_last_ff, out_last_in;
   logic       load;
   logic       final_byte;

   assign rsp_if.valid    = out_valid_ff;
   assign rsp_if.out_byte = out_byte_ff;
   assign rsp_if.out_last = out_last_ff;

   // load a byte whenever the output register is empty or being drained
   assign load       = head_valid && (!out_valid_ff || rsp_if.ready);
   assign final_byte = ((sel_ff + 2'd1) == head_entry.count);
   assign pop        = load && final_byte;

   always_comb begin
      sel_in       = sel_ff;
      out_valid_in = out_valid_ff;
      out_byte_in  = out_byte_ff;
      out_last_in  = out_last_ff;
      if (rsp_if.ready) begin
         out_valid_in = 1'b0;
      end
      if (load) begin
         out_valid_in = 1'b1;
         out_byte_in  = head_entry.bytes[sel_ff];
         out_last_in  = head_entry.last && final_byte;
         sel_in       = final_byte ? 2'd0 : sel_ff + 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sel_ff       <= 2'd0;
         out_valid_ff <= 1'b0;
      end else begin
         sel_ff       <= sel_in;
         out_valid_ff <= out_valid_in;
      end
      out_byte_ff <= out_byte_in;
      out_last_ff <= out_last_in;
   end

endmodule

// File: hw/rtl/url_percent_decoder_core.sv
// url_percent_decoder_core: top level of the url percent decoder
// depends on upd_pkg, upd_req_if, upd_rsp_if, upd_front, upd_queue, upd_back
//
// usage:
//   req_if carries the encoded string, one byte per transaction, with in_last
//   on the final byte. rsp_if returns decoded bytes with out_last on the
//   final decoded byte. '+' becomes a space, '%' plus two hex digits becomes
//   one byte, a broken escape is passed through as is.
//   throughput: one input byte per cycle while the queue is not full. an input
//   byte yields zero to three output bytes; the output side moves one byte per
//   cycle while rsp_if.ready is high, so the extra bytes of a broken escape
//   are absorbed by a four-entry queue between the classifier and the output
//   stage. an accepted byte is written into a queue entry, then loaded into
//   the output register, from which it appears on rsp_if.
//   stall: when rsp_if.ready is low the output register holds, the queue
//   fills and req_if.ready drops once four entries are waiting.
//   reset: synchronous, clears escape state, queue and output register.

module url_percent_decoder_core (
   input  logic       clock,
   input  logic       reset,
   upd_req_if.sink    req_if,
   upd_rsp_if.source  rsp_if
);
   import upd_pkg::*;

   logic      q_full;
   logic      push_valid;
   entry_type push_entry;
   logic      pop;
   logic      head_valid;
   entry_type head_entry;

   upd_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_if     (req_if),
      .q_full     (q_full),
      .push_valid (push_valid),
      .push_entry (push_entry)
   );

   upd_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_entry (push_entry),
      .full       (q_full),
      .pop        (pop),
      .head_valid (head_valid),
      .head_entry (head_entry)
   );

   upd_back u_back (
      .clock      (clock),
      .reset      (reset),
      .head_valid (head_valid),
      .head_entry (head_entry),
      .pop        (pop),
      .rsp_if     (rsp_if)
   );

endmodule
